// ----- sv/blrf_pkg.sv -----
// Shared types and codes for the binary range flip tree.
package blrf_pkg;

  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_FLIP  = 1'b1
  } kind_t;

  typedef enum logic [11:0] {
    S_CLR   = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_VISIT = 12'b0000_0000_0100,
    S_COVER = 12'b0000_0000_1000,
    S_PD    = 12'b0000_0001_0000,
    S_PDL   = 12'b0000_0010_0000,
    S_PDR   = 12'b0000_0100_0000,
    S_RET   = 12'b0000_1000_0000,
    S_CMA   = 12'b0001_0000_0000,
    S_CMB   = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_ROOT  = 12'b1000_0000_0000
  } state_t;

  localparam int unsigned POS_W = 10;
  localparam int unsigned OUT_W = 11;

endpackage

// ----- sv/binary_lnds_range_flip_tree_core.sv -----
// Binary string segment tree with lazy range flip, reports longest non-decreasing subsequence.
//
// Input channel (in_valid/in_ready): one word either writes one digit at
// in_first (in_kind = write) or flips positions in_first..in_last
// (in_kind = flip). Each word yields one output word on out_valid/out_ready
// carrying the longest non-decreasing subsequence of the whole string.
// Node state lives in one RAM of 2*LEAVES entries (4*LEAVES when LEAVES is
// not a power of two), walked depth first by a sequencer with a small
// per-level bounds stack. The RAM read is registered. A visited node is
// skipped, fully covered, or entered on the way down (a pending flip is
// pushed to the children first) and recombined on the way up. A flip of an
// empty range visits no node, and a flip touches at most four nodes a level.
// One word is in work at a time; in_ready is high only while idle.
// After reset a clearing pass writes every RAM entry to the empty node,
// one per cycle, before in_ready rises. A result sits in the output
// register while the next word is taken; when the receiver stalls with a
// result still held, the next result waits inside the block.
module binary_lnds_range_flip_tree_core
  import blrf_pkg::*;
#(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [POS_W-1:0]    in_first,
  input  logic [POS_W-1:0]    in_last,
  input  logic                in_digit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_longest
);

  localparam int unsigned IW    = $clog2(LEAVES);
  localparam int unsigned XW    = (IW > POS_W) ? IW : POS_W;
  localparam int unsigned CW    = $clog2(LEAVES + 1);
  localparam int unsigned ND    = ((LEAVES & (LEAVES - 1)) == 0) ? 2 * LEAVES : 4 * LEAVES;
  localparam int unsigned AW    = $clog2(ND);
  localparam int unsigned DEPTH = IW + 1;
  localparam int unsigned DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = 4 * CW + 1;

  typedef struct packed {
    logic          flip;
    logic [CW-1:0] down;
    logic [CW-1:0] up;
    logic [CW-1:0] ones;
    logic [CW-1:0] zeros;
  } node_t;

  function automatic node_t flip_node(input node_t n);
    node_t r;
    r.flip  = ~n.flip;
    r.down  = n.up;
    r.up    = n.down;
    r.ones  = n.zeros;
    r.zeros = n.ones;
    return r;
  endfunction

  function automatic node_t combine(input node_t a, input node_t b);
    node_t r;
    logic [CW-1:0] u0, u1, d0, d1;
    u0 = a.up + b.ones;
    u1 = a.zeros + b.up;
    d0 = a.down + b.zeros;
    d1 = a.ones + b.down;
    r.flip  = 1'b0;
    r.zeros = a.zeros + b.zeros;
    r.ones  = a.ones + b.ones;
    r.up    = (u0 > u1) ? u0 : u1;
    r.down  = (d0 > d1) ? d0 : d1;
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] v_r, v_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [IW-1:0] lo_s [DEPTH];
  logic [IW-1:0] hi_s [DEPTH];
  kind_t         kind_r;
  logic [XW-1:0] a_r, b_r;
  logic          digit_r;
  node_t         left_r;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_longest_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wnode, rnode;
  logic [NW-1:0] rdata;

  logic [IW-1:0] lo, hi, mid, phi;
  logic [XW-1:0] lo_x, hi_x;
  logic          disjoint, covered;
  logic [AW-1:0] v_l, v_r1;
  node_t         leaf;

  assign rnode = node_t'(rdata);

  blrf_ram #(.WIDTH(NW), .DEPTH(ND)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(NW'(wnode)),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign lo       = lo_s[d_r];
  assign hi       = hi_s[d_r];
  assign phi      = hi_s[d_r - 1'b1];
  assign mid      = lo + ((hi - lo) >> 1);
  assign lo_x     = XW'(lo);
  assign hi_x     = XW'(hi);
  assign disjoint = (a_r > hi_x) || (b_r < lo_x);
  assign covered  = (a_r <= lo_x) && (hi_x <= b_r);
  assign v_l      = {v_r[AW-2:0], 1'b0};
  assign v_r1     = {v_r[AW-2:0], 1'b1};

  always_comb begin
    leaf       = '0;
    leaf.zeros = CW'(!digit_r);
    leaf.ones  = CW'(digit_r);
    leaf.up    = CW'(1);
    leaf.down  = CW'(1);
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_longest = out_longest_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    v_nxt         = v_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = v_r;
    wnode         = rnode;
    raddr         = v_r;
    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wnode = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(ND - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          v_nxt = AW'(1);
          d_nxt = '0;
          if ((in_kind == KIND_FLIP) && (in_first > in_last)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_VISIT;
          end
        end
      end
      S_VISIT: begin
        if (disjoint) begin
          state_nxt = S_RET;
        end else if (covered) begin
          state_nxt = S_COVER;
        end else begin
          state_nxt = S_PD;
        end
      end
      S_COVER: begin
        we        = 1'b1;
        wnode     = (kind_r == KIND_FLIP) ? flip_node(rnode) : leaf;
        state_nxt = S_RET;
      end
      S_PD: begin
        if (rnode.flip) begin
          we         = 1'b1;
          wnode      = rnode;
          wnode.flip = 1'b0;
          raddr      = v_l;
          state_nxt  = S_PDL;
        end else begin
          v_nxt     = v_l;
          d_nxt     = d_r + 1'b1;
          state_nxt = S_VISIT;
        end
      end
      S_PDL: begin
        we        = 1'b1;
        waddr     = v_l;
        wnode     = flip_node(rnode);
        raddr     = v_r1;
        state_nxt = S_PDR;
      end
      S_PDR: begin
        we        = 1'b1;
        waddr     = v_r1;
        wnode     = flip_node(rnode);
        v_nxt     = v_l;
        d_nxt     = d_r + 1'b1;
        state_nxt = S_VISIT;
      end
      S_RET: begin
        if (d_r == '0) begin
          state_nxt = S_FIN;
        end else if (!v_r[0]) begin
          v_nxt     = v_r + 1'b1;
          state_nxt = S_VISIT;
        end else begin
          raddr     = {v_r[AW-1:1], 1'b0};
          v_nxt     = v_r >> 1;
          d_nxt     = d_r - 1'b1;
          state_nxt = S_CMA;
        end
      end
      S_CMA: begin
        raddr     = v_r1;
        state_nxt = S_CMB;
      end
      S_CMB: begin
        we        = 1'b1;
        wnode     = combine(left_r, rnode);
        state_nxt = S_RET;
      end
      S_FIN: begin
        raddr     = AW'(1);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        raddr = AW'(1);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      v_r         <= AW'(1);
      d_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      v_r         <= v_nxt;
      d_r         <= d_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      kind_r   <= kind_t'(in_kind);
      a_r      <= XW'(in_first);
      b_r      <= (in_kind == KIND_FLIP) ? XW'(in_last) : XW'(in_first);
      digit_r  <= in_digit;
      lo_s[0]  <= '0;
      hi_s[0]  <= IW'(LEAVES - 1);
    end
    if ((state_r == S_PD && !rnode.flip) || state_r == S_PDR) begin
      lo_s[d_r + 1'b1] <= lo;
      hi_s[d_r + 1'b1] <= mid;
    end
    if (state_r == S_RET && d_r != '0 && !v_r[0]) begin
      lo_s[d_r] <= hi + 1'b1;
      hi_s[d_r] <= phi;
    end
    if (state_r == S_CMA) begin
      left_r <= rnode;
    end
    if (state_r == S_ROOT && (!out_valid_r || out_ready)) begin
      out_longest_r <= OUT_W'(rnode.up);
    end
  end

endmodule

// ----- sv/blrf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module blrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
